// ===== rtl/sapq_pkg.sv =====
// Shared constants, codes and control types for the sorted-array priority queue.
package sapq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 32;

  localparam int KEY_IN_BITS = 32;
  localparam int COUNT_BITS  = 5;
  localparam int IN_BITS     = 40;
  localparam int OUT_BITS    = 40;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_REM_CAP,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_ins;
    logic load_rem;
    logic load_refuse;
    logic rd_pos;
    logic shift;
    logic place;
    logic cap_front;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic left_zero;
    logic greater;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/sorted_array_priority_queue.sv =====
// Top level of the sorted-array min-priority queue.
//
//  channel   dir  signals                     content
//  s_axis    in   s_tvalid s_tready s_tdata   opcode, key_in
//  m_axis    out  m_tvalid m_tready m_tdata   done_res, front_valid, front_key,
//                                             entry_count, is_full
//
// Insert: the walk reads keys from the tail toward the head; each key greater than
// the new key moves up one slot, and the new key fills the last hole. Each moved key
// costs one read and one write through the key store's single read port with its
// read register. Remove passes through ST_REM_CAP; a refused word goes to ST_EMIT.
// Reset empties the queue at once; the key store holds no reset.
// A result waits in the output register while the next word is taken in.
module sorted_array_priority_queue
  import sapq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_BITS-1:0]  s_tdata,  // [0] opcode, [32:1] key_in, [39:33] zero
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_BITS-1:0] m_tdata   // [0] done_res, [1] front_valid,
                                        // [33:2] front_key, [38:34] entry_count,
                                        // [39] is_full
);

  cmd_t cmd;
  sts_t sts;

  sapq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .opcode   (s_tdata[0]),
    .sts      (sts),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  sapq_dpath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

// ===== rtl/sapq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sapq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sapq_ctrl.sv =====
// Controller state machine: sequences insert walks, removes and result hand-off.
module sapq_ctrl
  import sapq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic opcode,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_INSERT) begin
            state_next = sts.full ? ST_EMIT : ST_INS_RD;
          end else begin
            state_next = sts.empty ? ST_EMIT : ST_REM_CAP;
          end
        end
      end
      ST_INS_RD: begin
        state_next = sts.left_zero ? ST_EMIT : ST_INS_CMP;
      end
      ST_INS_CMP: begin
        state_next = sts.greater ? ST_INS_RD : ST_EMIT;
      end
      ST_REM_CAP: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (opcode == OP_INSERT) begin
            cmd.load_ins    = !sts.full;
            cmd.load_refuse = sts.full;
          end else begin
            cmd.load_rem    = !sts.empty;
            cmd.load_refuse = sts.empty;
          end
        end
      end
      ST_INS_RD: begin
        cmd.rd_pos = !sts.left_zero;
        cmd.place  = sts.left_zero;
      end
      ST_INS_CMP: begin
        cmd.shift = sts.greater;
        cmd.place = !sts.greater;
      end
      ST_REM_CAP: begin
        cmd.cap_front = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/sapq_dpath.sv =====
// Datapath: ring pointers, key store, front key register and result register.
module sapq_dpath
  import sapq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [IN_BITS-1:0]  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_BITS-1:0] out_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  logic [IW-1:0]       head;
  logic [IW-1:0]       tail;
  logic [CW-1:0]       count;
  logic [IW-1:0]       pos;
  logic [IW-1:0]       slot;
  logic [CW-1:0]       left;
  logic [KEY_BITS-1:0] key;
  logic [KEY_BITS-1:0] front;
  logic                done;

  logic [KEY_BITS-1:0] key_new;
  logic [IW-1:0]       head_inc;
  logic [IW-1:0]       tail_inc;
  logic [IW-1:0]       pos_dec;
  logic                ram_we;
  logic [IW-1:0]       ram_raddr;
  logic [KEY_BITS-1:0] ram_wdata;
  logic [KEY_BITS-1:0] ram_rdata;
  logic                res_valid;
  logic [KEY_IN_BITS-1:0] res_key;

  function automatic logic is_full_bit(input logic [CW-1:0] c);
    return (c == CW'(CAPACITY));
  endfunction

  assign key_new  = KEY_BITS'(in_data[KEY_IN_BITS:1]);
  assign head_inc = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign tail_inc = (tail == LAST_IDX) ? '0 : tail + 1'b1;
  assign pos_dec  = (pos == '0) ? LAST_IDX : pos - 1'b1;

  assign sts.full      = (count == CW'(CAPACITY));
  assign sts.empty     = (count == '0);
  assign sts.left_zero = (left == '0);
  assign sts.greater   = (ram_rdata > key);
  assign sts.out_free  = !out_valid || out_ready;

  // a shifted key moves up into the hole; the new key fills the last hole
  assign ram_we    = cmd.shift || cmd.place;
  assign ram_wdata = cmd.shift ? ram_rdata : key;
  assign ram_raddr = cmd.rd_pos ? pos : head_inc;

  sapq_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= LAST_IDX;
      count     <= '0;
      left      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_ins) begin
        tail  <= tail_inc;
        count <= count + 1'b1;
        left  <= count;
      end else if (cmd.load_rem) begin
        head  <= head_inc;
        count <= count - 1'b1;
      end
      if (cmd.shift) begin
        left <= left - 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ins) begin
      key  <= key_new;
      pos  <= tail;
      slot <= tail_inc;
      done <= 1'b1;
      if (count == '0 || key_new < front) begin
        front <= key_new;
      end
    end
    if (cmd.load_rem) begin
      done <= 1'b1;
    end
    if (cmd.load_refuse) begin
      done <= 1'b0;
    end
    if (cmd.shift) begin
      slot <= pos;
      pos  <= pos_dec;
    end
    if (cmd.cap_front) begin
      front <= ram_rdata;
    end
  end

  assign res_valid = (count != '0);
  assign res_key   = res_valid ? KEY_IN_BITS'(front) : '0;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {is_full_bit(count), COUNT_BITS'(count), res_key, res_valid, done};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("stored count above capacity");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_pos || cmd.shift) |-> (left != '0 && left < count))
    else $error("insert walk longer than the stored run");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result loaded over an untaken word");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_ins || cmd.load_rem || cmd.load_refuse) |-> !ram_we)
    else $error("key store written while taking a new word");

endmodule
